// ===== design/itmr_pkg.sv =====
// itmr_pkg: shared types and constants of the interval timer register block
// item and result structs, action codes, register indexes, control bit positions
// no dependencies
`timescale 1ns / 1ps

package itmr_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned COUNT_W  = 2 * WORD_W;

    // item kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // word register map
    localparam logic [INDEX_W-1:0] REG_STATUS    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_CONTROL   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_PERIOD_LO = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PERIOD_HI = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SNAP_LO   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SNAP_HI   = 3'd5;

    // control word bit positions
    localparam int unsigned CTL_IEN_BIT   = 0;
    localparam int unsigned CTL_CONT_BIT  = 1;
    localparam int unsigned CTL_START_BIT = 2;
    localparam int unsigned CTL_STOP_BIT  = 3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  reg_index;
        logic [WORD_W-1:0]   write_data;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq_level;
    } t_result;

    // timer status seen by the top level
    typedef struct packed {
        logic timeout;
        logic running;
        logic irq_en;
    } t_status;

endpackage

// ===== design/itmr_ifs.sv =====
// itmr_ifs: valid/ready channel interfaces for items and results
// depends on itmr_pkg for field widths
`timescale 1ns / 1ps

interface itmr_in_if;
    import itmr_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  reg_index;
    logic [WORD_W-1:0]   write_data;

    modport source (output valid, output action, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input action, input reg_index, input write_data,
                    output ready);
endinterface

interface itmr_out_if;
    import itmr_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_data;
    logic              irq_level;

    modport source (output valid, output read_data, output irq_level, input ready);
    modport sink   (input valid, input read_data, input irq_level, output ready);
endinterface

// ===== design/itmr_in_stage.sv =====
// itmr_in_stage: input register that holds one accepted item
// depends on itmr_pkg
`timescale 1ns / 1ps

module itmr_in_stage
    import itmr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== design/itmr_core.sv =====
// itmr_core: timer state and its update for one item per cycle while i_fire is high
// depends on itmr_pkg
`timescale 1ns / 1ps

module itmr_core
    import itmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result,
    output t_status o_status
);

    logic               r_timeout, n_timeout;
    logic               r_running, n_running;
    logic [1:0]         r_ctrl,    n_ctrl;
    logic [WORD_W-1:0]  r_per_lo,  n_per_lo;
    logic [WORD_W-1:0]  r_per_hi,  n_per_hi;
    logic [WORD_W-1:0]  r_snap_lo, n_snap_lo;
    logic [WORD_W-1:0]  r_snap_hi, n_snap_hi;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic [WORD_W-1:0]  s_rd;
    logic [COUNT_W-1:0] s_period;

    always_comb begin
        n_timeout = r_timeout;
        n_running = r_running;
        n_ctrl    = r_ctrl;
        n_per_lo  = r_per_lo;
        n_per_hi  = r_per_hi;
        n_snap_lo = r_snap_lo;
        n_snap_hi = r_snap_hi;
        n_count   = r_count;
        s_rd      = '0;
        s_period  = {r_per_hi, r_per_lo};
        unique case (t_action'(i_item.action))
            ACT_TICK: begin
                if (r_running) begin
                    // count of 0 or 1 expires
                    if (r_count[COUNT_W-1:1] == '0) begin
                        n_timeout = 1'b1;
                        if (r_ctrl[CTL_CONT_BIT]) begin
                            n_count = s_period;
                        end else begin
                            n_count   = '0;
                            n_running = 1'b0;
                        end
                    end else begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end
            end
            ACT_READ: begin
                unique case (i_item.reg_index)
                    REG_STATUS:    s_rd = {{(WORD_W-2){1'b0}}, r_running, r_timeout};
                    REG_CONTROL:   s_rd = {{(WORD_W-2){1'b0}}, r_ctrl};
                    REG_PERIOD_LO: s_rd = r_per_lo;
                    REG_PERIOD_HI: s_rd = r_per_hi;
                    REG_SNAP_LO:   s_rd = r_snap_lo;
                    REG_SNAP_HI:   s_rd = r_snap_hi;
                    default:       s_rd = '0;
                endcase
            end
            ACT_WRITE: begin
                unique case (i_item.reg_index) inside
                    REG_STATUS: n_timeout = 1'b0;
                    REG_CONTROL: begin
                        n_ctrl = i_item.write_data[1:0];
                        // start and stop both judged against the old running flag
                        if (i_item.write_data[CTL_START_BIT] && !r_running) begin
                            n_count   = s_period;
                            n_running = 1'b1;
                        end
                        if (i_item.write_data[CTL_STOP_BIT] && r_running) begin
                            n_running = 1'b0;
                        end
                    end
                    REG_PERIOD_LO, REG_PERIOD_HI: begin
                        if (i_item.reg_index == REG_PERIOD_LO) begin
                            n_per_lo = i_item.write_data;
                        end else begin
                            n_per_hi = i_item.write_data;
                        end
                        if (r_running) begin
                            n_count = {n_per_hi, n_per_lo};
                        end
                    end
                    REG_SNAP_LO, REG_SNAP_HI: begin
                        n_snap_lo = r_count[WORD_W-1:0];
                        n_snap_hi = r_count[COUNT_W-1:WORD_W];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_result.read_data = s_rd;
    assign o_result.irq_level = n_timeout & n_ctrl[CTL_IEN_BIT];
    assign o_status.timeout   = r_timeout;
    assign o_status.running   = r_running;
    assign o_status.irq_en    = r_ctrl[CTL_IEN_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 1'b0;
            r_running <= 1'b0;
            r_ctrl    <= '0;
            r_per_lo  <= '0;
            r_per_hi  <= '0;
            r_snap_lo <= '0;
            r_snap_hi <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_timeout <= n_timeout;
            r_running <= n_running;
            r_ctrl    <= n_ctrl;
            r_per_lo  <= n_per_lo;
            r_per_hi  <= n_per_hi;
            r_snap_lo <= n_snap_lo;
            r_snap_hi <= n_snap_hi;
            r_count   <= n_count;
        end
    end

endmodule

// ===== design/itmr_out_stage.sv =====
// itmr_out_stage: result register toward the output channel
// depends on itmr_pkg
`timescale 1ns / 1ps

module itmr_out_stage
    import itmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/interval_timer_regs.sv =====
// interval_timer_regs: top level of the 32-bit interval timer register block
// depends on itmr_pkg, itmr_ifs, itmr_in_stage, itmr_core, itmr_out_stage
`timescale 1ns / 1ps

// A 32-bit down-counting interval timer behind six 16-bit word registers
// (status, control, period low/high, snapshot low/high). Each item on i_in is
// a tick, a register read or a register write, and each gives exactly one
// result item on o_out carrying the read data (zero for ticks and writes) and
// the interrupt level after the item (timeout and enable). The block takes one
// item per clock as long as o_out is drained: an item lands in the input
// register at the edge that accepts it, its state update and result are formed
// combinationally while it sits there, and both are registered, in the timer
// state and the result register, at an edge at which the result register can
// take the result; throughput is one item per cycle as long as o_out is
// drained. A stalled output keeps the result register full; the input register
// still takes one more item before i_in.ready drops.
module interval_timer_regs
    import itmr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    itmr_in_if.sink    i_in,
    itmr_out_if.source o_out
);

    t_item   s_in_item;
    t_item   s_item;
    logic    s_item_valid;
    logic    s_fire;
    logic    s_can_load;
    t_result s_result;
    t_result s_out_result;
    t_status s_status;

    // pack the channel fields
    assign s_in_item.action     = i_in.action;
    assign s_in_item.reg_index  = i_in.reg_index;
    assign s_in_item.write_data = i_in.write_data;

    // an item is processed when the result register can take its result
    assign s_fire = s_item_valid && s_can_load;

    itmr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (s_in_item),
        .o_ready (i_in.ready),
        .i_take  (s_fire),
        .o_valid (s_item_valid),
        .o_item  (s_item)
    );

    // timer state, updated once per processed item
    itmr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s_fire),
        .i_item   (s_item),
        .o_result (s_result),
        .o_status (s_status)
    );

    itmr_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_fire),
        .i_result   (s_result),
        .o_can_load (s_can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (s_out_result)
    );

    assign o_out.read_data = s_out_result.read_data;
    assign o_out.irq_level = s_out_result.irq_level;

    // timeout is only ever raised by a tick
    a_timeout_by_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(s_status.timeout) |-> $past(s_fire && s_item.action == ACT_TICK))
        else $error("timeout set without a tick");

    // the timer stops only on a tick or a control write
    a_stop_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_status.running) |-> $past(s_fire && (s_item.action == ACT_TICK
            || (s_item.action == ACT_WRITE && s_item.reg_index == REG_CONTROL))))
        else $error("running cleared without cause");

    // a held item is never dropped from the input register
    a_item_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_item_valid && !s_fire) |=> (s_item_valid && $stable(s_item)))
        else $error("pending item lost");

endmodule
